// ----- hdl/vrf_pkg.sv -----
// Shared constants, codes and types of the multivariate recursive filter.
package vrf_pkg;

  // Default sizes of the filter
  localparam int DEF_MAX_OUT_DIM  = 4;
  localparam int DEF_MAX_IN_DIM   = 4;
  localparam int DEF_MAX_AR_ORDER = 4;
  localparam int DEF_MAX_MA_ORDER = 4;
  localparam int DEF_FRAC_BITS    = 16;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int DIM_W  = 3;
  localparam int STEP_W = 16;
  localparam int COL_W  = 6;

  // Request codes
  localparam logic [1:0] REQ_AR     = 2'd0;
  localparam logic [1:0] REQ_MA     = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_OUT_DIM    = 3'd0;
  localparam logic [2:0] REG_IN_DIM     = 3'd1;
  localparam logic [2:0] REG_AR_ORDER   = 3'd2;
  localparam logic [2:0] REG_MA_ORDER   = 3'd3;
  localparam logic [2:0] REG_START_STEP = 3'd4;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// ----- hdl/varma_recursive_filter.sv -----
// Top level of the multivariate ARMA recursive filter.
// Coefficient items and sample items that do not close a step are taken at once while the filter is idle.
// A closing sample item makes one word per output row; a filtered row takes
// (ma_order+1)*in_dim + ar_order*out_dim products, one product per cycle through
// the single shared multiply-accumulate unit, besides the steps to start, drain
// its three-stage pipeline and hand the word out. Preset history rows need no
// products. The input is stalled until the step's last word is registered.
module varma_recursive_filter #(
  parameter int MAX_OUT_DIM  = vrf_pkg::DEF_MAX_OUT_DIM,
  parameter int MAX_IN_DIM   = vrf_pkg::DEF_MAX_IN_DIM,
  parameter int MAX_AR_ORDER = vrf_pkg::DEF_MAX_AR_ORDER,
  parameter int MAX_MA_ORDER = vrf_pkg::DEF_MAX_MA_ORDER,
  parameter int FRAC_BITS    = vrf_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [1:0]         coef_row,
  input  logic [4:0]         coef_col,
  input  logic signed [31:0] coef_value,
  input  logic [1:0]         component_index,
  input  logic signed [31:0] u_value,
  input  logic signed [31:0] preset_value,
  input  logic               step_last,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] y_value,
  output logic [1:0]         out_row,
  output logic               run_last,
  output logic               saturated
);
  import vrf_pkg::*;

  localparam int AR_COLS  = MAX_OUT_DIM * MAX_AR_ORDER;
  localparam int MA_COLS  = MAX_IN_DIM * (MAX_MA_ORDER + 1);
  localparam int AR_DEPTH = MAX_OUT_DIM * AR_COLS;
  localparam int MA_DEPTH = MAX_OUT_DIM * MA_COLS;
  localparam int AR_AW    = (AR_DEPTH > 1) ? $clog2(AR_DEPTH) : 1;
  localparam int MA_AW    = (MA_DEPTH > 1) ? $clog2(MA_DEPTH) : 1;
  localparam int IW       = (MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM) : 1;
  localparam int OW       = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;
  localparam int KW       = (MAX_MA_ORDER > 0) ? $clog2(MAX_MA_ORDER + 1) : 1;
  localparam int LW       = (MAX_AR_ORDER > 1) ? $clog2(MAX_AR_ORDER) : 1;
  localparam int M_CAP    = (MAX_OUT_DIM < 4) ? MAX_OUT_DIM : 4;

  typedef enum logic [2:0] {S_IDLE, S_START, S_ISSUE, S_DRAIN, S_EMIT} state_t;

  state_t state;

  // configuration registers
  logic [DIM_W-1:0]  cfg_out_dim;
  logic [DIM_W-1:0]  cfg_in_dim;
  logic [DIM_W-1:0]  cfg_ar_order;
  logic [DIM_W-1:0]  cfg_ma_order;
  logic [STEP_W-1:0] cfg_start_step;

  // histories and step state
  logic signed [DATA_W-1:0] in_hist  [0:MAX_MA_ORDER][0:MAX_IN_DIM-1];
  logic signed [DATA_W-1:0] out_hist [0:MAX_AR_ORDER-1][0:MAX_OUT_DIM-1];
  logic signed [DATA_W-1:0] preset   [0:3];
  logic signed [DATA_W-1:0] newy     [0:3];
  logic [STEP_W-1:0]        step_count;

  // sequencer counters
  logic [1:0]       r;
  logic             filt_q;
  logic             is_ar;
  logic [DIM_W-1:0] k;
  logic [DIM_W-1:0] j;
  logic [DIM_W-1:0] lidx;
  logic [COL_W-1:0] ma_col;
  logic [COL_W-1:0] ar_base;

  // issue stage
  logic                     issue_v;
  logic                     issue_ar;
  logic signed [DATA_W-1:0] hv;

  logic [DIM_W-1:0]  m_eff;
  logic [DIM_W-1:0]  n_eff;
  logic [DIM_W-1:0]  p_eff;
  logic [DIM_W-1:0]  q_eff;
  logic [STEP_W-1:0] start_m1;
  logic              filt;
  logic              in_acc;
  logic              cfg_wr;
  logic              out_free;

  logic              ar_we;
  logic              ma_we;
  logic [AR_AW-1:0]  ar_addr;
  logic [MA_AW-1:0]  ma_addr;
  logic [DATA_W-1:0] ar_rd;
  logic [DATA_W-1:0] ma_rd;

  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_busy;
  logic signed [DATA_W-1:0] y_sat;
  logic                     sat_flag;
  logic signed [DATA_W-1:0] y_row;

  // Limit the register values to the sizes built
  always_comb begin
    m_eff = cfg_out_dim;
    if (int'(cfg_out_dim) > M_CAP) m_eff = DIM_W'(M_CAP);
    if (cfg_out_dim == '0) m_eff = DIM_W'(1);
    n_eff = (int'(cfg_in_dim) > MAX_IN_DIM) ? DIM_W'(MAX_IN_DIM) : cfg_in_dim;
    p_eff = (int'(cfg_ar_order) > MAX_AR_ORDER) ? DIM_W'(MAX_AR_ORDER) : cfg_ar_order;
    q_eff = (int'(cfg_ma_order) > MAX_MA_ORDER) ? DIM_W'(MAX_MA_ORDER) : cfg_ma_order;
    start_m1 = (cfg_start_step == '0) ? '0 : cfg_start_step - STEP_W'(1);
    filt = step_count >= start_m1;
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[4:2])
      REG_OUT_DIM:    prdata = 32'(cfg_out_dim);
      REG_IN_DIM:     prdata = 32'(cfg_in_dim);
      REG_AR_ORDER:   prdata = 32'(cfg_ar_order);
      REG_MA_ORDER:   prdata = 32'(cfg_ma_order);
      REG_START_STEP: prdata = 32'(cfg_start_step);
      default:        prdata = '0;
    endcase
  end

  // Handshakes
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  // Coefficient memories: write on load, else read the current term
  assign ar_we = in_acc && (req_type == REQ_AR) && (int'(coef_row) < MAX_OUT_DIM)
                 && (int'(coef_col) < AR_COLS);
  assign ma_we = in_acc && (req_type == REQ_MA) && (int'(coef_row) < MAX_OUT_DIM)
                 && (int'(coef_col) < MA_COLS);

  always_comb begin
    if (state == S_IDLE) begin
      ar_addr = AR_AW'(int'(coef_row) * AR_COLS + int'(coef_col));
      ma_addr = MA_AW'(int'(coef_row) * MA_COLS + int'(coef_col));
    end else begin
      ar_addr = AR_AW'(int'(r) * AR_COLS + int'(ar_base) + int'(j));
      ma_addr = MA_AW'(int'(r) * MA_COLS + int'(ma_col));
    end
  end

  vrf_ram #(.WIDTH(DATA_W), .DEPTH(AR_DEPTH)) u_ar_ram (
    .clk   (clk),
    .we    (ar_we),
    .addr  (ar_addr),
    .wdata (coef_value),
    .rdata (ar_rd)
  );

  vrf_ram #(.WIDTH(DATA_W), .DEPTH(MA_DEPTH)) u_ma_ram (
    .clk   (clk),
    .we    (ma_we),
    .addr  (ma_addr),
    .wdata (coef_value),
    .rdata (ma_rd)
  );

  // Shared multiply-accumulate unit
  assign mac_ctrl.clear = (state == S_START);
  assign mac_ctrl.valid = issue_v;

  vrf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .coef (issue_ar ? ar_rd : ma_rd),
    .x    (hv),
    .acc  (acc),
    .busy (mac_busy)
  );

  // Clip the sum to 32 bits
  always_comb begin
    sat_flag = 1'b0;
    y_sat    = acc[DATA_W-1:0];
    if (!((&acc[ACC_W-1:DATA_W-1]) || !(|acc[ACC_W-1:DATA_W-1]))) begin
      sat_flag = 1'b1;
      y_sat    = acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    y_row = filt_q ? y_sat : preset[r];
  end

  // Sequencer, histories and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cfg_out_dim    <= DIM_W'(1);
      cfg_in_dim     <= DIM_W'(1);
      cfg_ar_order   <= '0;
      cfg_ma_order   <= '0;
      cfg_start_step <= STEP_W'(1);
      step_count     <= '0;
      issue_v        <= 1'b0;
      out_valid      <= 1'b0;
      for (int a = 0; a <= MAX_MA_ORDER; a++) begin
        for (int b = 0; b < MAX_IN_DIM; b++) begin
          in_hist[a][b] <= '0;
        end
      end
      for (int a = 0; a < MAX_AR_ORDER; a++) begin
        for (int b = 0; b < MAX_OUT_DIM; b++) begin
          out_hist[a][b] <= '0;
        end
      end
      for (int b = 0; b < 4; b++) begin
        preset[b] <= '0;
      end
    end else begin
      // take register writes
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_OUT_DIM:    cfg_out_dim    <= pwdata[DIM_W-1:0];
          REG_IN_DIM:     cfg_in_dim     <= pwdata[DIM_W-1:0];
          REG_AR_ORDER:   cfg_ar_order   <= pwdata[DIM_W-1:0];
          REG_MA_ORDER:   cfg_ma_order   <= pwdata[DIM_W-1:0];
          REG_START_STEP: cfg_start_step <= pwdata[STEP_W-1:0];
          default: ;
        endcase
      end

      // drop the output word once taken, unless a new one replaces it
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      issue_v <= (state == S_ISSUE);

      case (state)
        S_IDLE: begin
          if (in_acc && req_type == REQ_SAMPLE) begin
            if (component_index < n_eff) begin
              in_hist[0][IW'(component_index)] <= u_value;
            end
            preset[component_index] <= preset_value;
            if (step_last) begin
              r      <= '0;
              filt_q <= filt;
              state  <= filt ? S_START : S_EMIT;
            end
          end
        end

        S_START: begin
          k       <= '0;
          j       <= '0;
          lidx    <= '0;
          ma_col  <= '0;
          ar_base <= COL_W'((int'(p_eff) - 1) * int'(m_eff));
          if (n_eff != '0) begin
            is_ar <= 1'b0;
            state <= S_ISSUE;
          end else if (p_eff != '0) begin
            is_ar <= 1'b1;
            state <= S_ISSUE;
          end else begin
            state <= S_DRAIN;
          end
        end

        S_ISSUE: begin
          // issue one product and advance the term counters
          issue_ar <= is_ar;
          hv <= is_ar ? out_hist[LW'(lidx)][OW'(j)] : in_hist[KW'(k)][IW'(j)];
          if (!is_ar) begin
            ma_col <= ma_col + COL_W'(1);
            if (j == n_eff - DIM_W'(1)) begin
              j <= '0;
              if (k == q_eff) begin
                if (p_eff != '0) begin
                  is_ar <= 1'b1;
                end else begin
                  state <= S_DRAIN;
                end
              end else begin
                k <= k + DIM_W'(1);
              end
            end else begin
              j <= j + DIM_W'(1);
            end
          end else begin
            if (j == m_eff - DIM_W'(1)) begin
              j <= '0;
              if (lidx == p_eff - DIM_W'(1)) begin
                state <= S_DRAIN;
              end else begin
                lidx    <= lidx + DIM_W'(1);
                ar_base <= ar_base - COL_W'(m_eff);
              end
            end else begin
              j <= j + DIM_W'(1);
            end
          end
        end

        S_DRAIN: begin
          if (!issue_v && !mac_busy) begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            y_value   <= y_row;
            out_row   <= r;
            saturated <= filt_q & sat_flag;
            run_last  <= ({1'b0, r} == m_eff - DIM_W'(1));
            newy[r]   <= y_row;
            if ({1'b0, r} == m_eff - DIM_W'(1)) begin
              // close the step: shift histories and clear the current block
              for (int a = MAX_AR_ORDER - 1; a > 0; a--) begin
                for (int b = 0; b < MAX_OUT_DIM; b++) begin
                  out_hist[a][b] <= out_hist[a-1][b];
                end
              end
              for (int b = 0; b < MAX_OUT_DIM; b++) begin
                if (b < int'(m_eff)) begin
                  out_hist[0][b] <= (b == int'(r)) ? y_row : newy[2'(b)];
                end else begin
                  out_hist[0][b] <= '0;
                end
              end
              for (int a = MAX_MA_ORDER; a > 0; a--) begin
                for (int b = 0; b < MAX_IN_DIM; b++) begin
                  in_hist[a][b] <= in_hist[a-1][b];
                end
              end
              for (int b = 0; b < MAX_IN_DIM; b++) begin
                in_hist[0][b] <= '0;
              end
              for (int b = 0; b < 4; b++) begin
                preset[b] <= '0;
              end
              if (step_count != {STEP_W{1'b1}}) begin
                step_count <= step_count + STEP_W'(1);
              end
              state <= S_IDLE;
            end else begin
              r     <= r + 2'd1;
              state <= filt_q ? S_START : S_EMIT;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // the last row of a step carries the closing mark
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_last == ({1'b0, out_row} == m_eff - DIM_W'(1))))
    else $error("run_last does not match the last output row");

  // no product in flight while new items are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!issue_v && !mac_busy))
    else $error("multiply pipeline busy while idle");

  // a new output word comes only from the emit state
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("output word loaded outside the emit state");
`endif

endmodule

// ----- hdl/vrf_ram.sv -----
// Generic single-port RAM with registered read.
module vrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write and read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/vrf_mac.sv -----
// Shared multiply, round and accumulate unit of the filter.
module vrf_mac #(
  parameter int FRAC_BITS = vrf_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vrf_pkg::mac_ctrl_t                ctrl,
  input  logic signed [vrf_pkg::DATA_W-1:0] coef,
  input  logic signed [vrf_pkg::DATA_W-1:0] x,
  output logic signed [vrf_pkg::ACC_W-1:0]  acc,
  output logic                              busy
);
  import vrf_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] rnd;
  logic                    prod_v;
  logic                    rnd_v;

  // Multiply, then round half up, then accumulate with wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
      rnd_v  <= 1'b0;
      acc    <= '0;
    end else begin
      prod_v <= ctrl.valid;
      rnd_v  <= prod_v;
      if (ctrl.clear) begin
        acc <= '0;
      end else if (rnd_v) begin
        acc <= acc + rnd;
      end
    end
    prod <= coef * x;
    rnd  <= (prod + HALF) >>> FRAC_BITS;
  end

  assign busy = prod_v | rnd_v;

endmodule
